// File: sv/qpht_pkg.sv
`timescale 1ns / 1ps
// Package for the quadratic-probe hash table: sizes, codes and shared types.
// Depends on nothing; every other file of the block but qpht_ram uses it.
package qpht_pkg;

	localparam int TABLE_SIZE = 16;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int KEY_W      = 31;
	localparam int MODE_W     = 2;
	localparam int STATUS_W   = 2;
	localparam int SLOT_W     = 4;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_SEARCH = 2'd1,
		MODE_DELETE = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HOME,
		S_READ,
		S_CHECK
	} state_t;

	typedef struct packed {
		logic start;
		logic advance;
	} probe_ctrl_t;

	typedef struct packed {
		logic             ready;
		logic             last;
		logic [IDX_W-1:0] addr;
	} probe_stat_t;

endpackage

// File: sv/qpht_req_if.sv
`timescale 1ns / 1ps
// Request channel: one word carries a mode and a key.
// Depends on qpht_pkg.
interface qpht_req_if;
	logic                          valid;
	logic                          ready;
	logic [qpht_pkg::MODE_W-1:0]   mode;
	logic [qpht_pkg::KEY_W-1:0]    key;

	modport source (output valid, output mode, output key, input ready);
	modport sink   (input valid, input mode, input key, output ready);
endinterface

// File: sv/qpht_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: one word carries a status and a slot index.
// Depends on qpht_pkg.
interface qpht_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [qpht_pkg::STATUS_W-1:0]   status;
	logic [qpht_pkg::SLOT_W-1:0]     slot_index;

	modport source (output valid, output status, output slot_index, input ready);
	modport sink   (input valid, input status, input slot_index, output ready);
endinterface

// File: sv/qpht_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module qpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: sv/qpht_probe.sv
`timescale 1ns / 1ps
// Probe address generator: home slot (key mod table size) and quadratic offsets.
// Depends on qpht_pkg.
module qpht_probe (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [qpht_pkg::KEY_W-1:0] key,
	input  qpht_pkg::probe_ctrl_t    ctrl,
	output qpht_pkg::probe_stat_t    stat
);
	import qpht_pkg::*;

	localparam int BCNT_W = $clog2(KEY_W);
	localparam bit POW2 = (TABLE_SIZE == (1 << IDX_W));
	localparam logic [IDX_W:0] T_EXT = (IDX_W + 1)'(TABLE_SIZE);
	localparam logic [BCNT_W-1:0] BCNT_LAST = BCNT_W'(KEY_W - 1);
	localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(TABLE_SIZE - 1);

	logic [IDX_W-1:0]  home_q;   // running remainder while reducing
	logic [IDX_W-1:0]  off_q;    // i*i mod size
	logic [IDX_W-1:0]  step_q;   // (2i+1) mod size
	logic [IDX_W-1:0]  cnt_q;    // probe number i
	logic [KEY_W-1:0]  key_sh_q;
	logic [BCNT_W-1:0] bcnt_q;
	logic              busy_q;
	logic              rdy_q;

	logic [IDX_W:0] rem_t, rem_n;
	logic [IDX_W:0] addr_t, off_t, step_t;
	logic [IDX_W-1:0] addr_n, off_n, step_n;

	always_comb begin
		rem_t  = {home_q, key_sh_q[KEY_W-1]};
		rem_n  = (rem_t >= T_EXT) ? rem_t - T_EXT : rem_t;
		addr_t = {1'b0, home_q} + {1'b0, off_q};
		addr_n = (addr_t >= T_EXT) ? IDX_W'(addr_t - T_EXT) : IDX_W'(addr_t);
		off_t  = {1'b0, off_q} + {1'b0, step_q};
		off_n  = (off_t >= T_EXT) ? IDX_W'(off_t - T_EXT) : IDX_W'(off_t);
		step_t = {1'b0, step_q} + (IDX_W + 1)'(2);
		step_n = (step_t >= T_EXT) ? IDX_W'(step_t - T_EXT) : IDX_W'(step_t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rdy_q  <= 1'b0;
		end else if (ctrl.start) begin
			busy_q <= !POW2;
			rdy_q  <= POW2;
		end else if (busy_q && bcnt_q == BCNT_LAST) begin
			busy_q <= 1'b0;
			rdy_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			home_q   <= POW2 ? key[IDX_W-1:0] : '0;
			key_sh_q <= key;
			bcnt_q   <= '0;
			off_q    <= '0;
			step_q   <= IDX_W'(1);
			cnt_q    <= '0;
		end else begin
			if (busy_q) begin
				// one key bit per cycle into the remainder
				home_q   <= IDX_W'(rem_n);
				key_sh_q <= {key_sh_q[KEY_W-2:0], 1'b0};
				bcnt_q   <= bcnt_q + BCNT_W'(1);
			end
			if (ctrl.advance) begin
				off_q  <= off_n;
				step_q <= step_n;
				cnt_q  <= cnt_q + IDX_W'(1);
			end
		end
	end

	assign stat.ready = rdy_q;
	assign stat.last  = (cnt_q == CNT_LAST);
	assign stat.addr  = addr_n;
endmodule

// File: sv/quadratic_probe_hash_table.sv
`timescale 1ns / 1ps
// Open-addressing hash table of 31-bit keys with quadratic probing over TABLE_SIZE
// slots. Each request word (mode, key) gives exactly one response word (status,
// slot_index). Insert takes the first free probed slot (duplicates allowed),
// search returns the first matching slot and stops at a free one, delete empties
// the matching slot outright. Probe i visits (key mod size + i*i) mod size; after
// TABLE_SIZE probes insert answers full and search/delete answer not found. The
// unused mode code answers not found and leaves the table alone. Keys live in a
// RAM with a registered read; valid bits are flops cleared at reset, so no
// clearing pass is needed. One request is worked on at a time: after acceptance
// the home slot is formed, then each probe does one RAM read and one compare,
// and the response word is registered once the output register is free. When
// TABLE_SIZE is not a power of two the home slot is reduced one key bit per cycle.
// A finished response sits in an output register, and the next request is taken
// meanwhile.
// Depends on qpht_pkg, qpht_req_if, qpht_rsp_if, qpht_ram and qpht_probe.
module quadratic_probe_hash_table (
	input  logic         clk,
	input  logic         arst_n,
	qpht_req_if.sink     req,
	qpht_rsp_if.source   rsp
);
	import qpht_pkg::*;

	state_t                state_q, state_n;
	logic [MODE_W-1:0]     mode_q;
	logic [KEY_W-1:0]      key_q;
	logic [TABLE_SIZE-1:0] valid_q;
	logic                  rsp_valid_q;
	logic [STATUS_W-1:0]   rsp_status_q;
	logic [SLOT_W-1:0]     rsp_slot_q;

	probe_ctrl_t  pctrl;
	probe_stat_t  pstat;
	logic [KEY_W-1:0] rdata;

	logic    accept, rsp_free, vld, hit;
	logic    finish, do_write, do_clear, commit, cont;
	status_t fin_status;

	qpht_probe u_probe (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (req.key),
		.ctrl   (pctrl),
		.stat   (pstat)
	);

	// key store; the entry read is only compared when its valid bit is set
	qpht_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TABLE_SIZE)
	) u_keys (
		.clk   (clk),
		.we    (commit && do_write),
		.waddr (pstat.addr),
		.wdata (key_q),
		.re    (state_q == S_READ),
		.raddr (pstat.addr),
		.rdata (rdata)
	);

	assign accept   = req.valid && req.ready;
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign vld      = valid_q[pstat.addr];
	assign hit      = vld && (rdata == key_q);

	// per-probe decision, evaluated while in S_CHECK
	always_comb begin
		finish     = 1'b0;
		do_write   = 1'b0;
		do_clear   = 1'b0;
		fin_status = ST_NOT_FOUND;
		case (mode_q)
			MODE_INSERT: begin
				if (!vld) begin
					finish     = 1'b1;
					do_write   = 1'b1;
					fin_status = ST_OK;
				end else if (pstat.last) begin
					finish     = 1'b1;
					fin_status = ST_FULL;
				end
			end
			MODE_SEARCH, MODE_DELETE: begin
				if (!vld) begin
					finish = 1'b1;
				end else if (hit) begin
					finish     = 1'b1;
					do_clear   = (mode_q == MODE_DELETE);
					fin_status = ST_OK;
				end else if (pstat.last) begin
					finish = 1'b1;
				end
			end
			default: begin
				finish = 1'b1;
			end
		endcase
	end

	// hold the final probe until the output register can take the word
	assign commit = (state_q == S_CHECK) && finish && rsp_free;
	assign cont   = (state_q == S_CHECK) && !finish;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE:  if (accept) state_n = S_HOME;
			S_HOME:  if (pstat.ready) state_n = S_READ;
			S_READ:  state_n = S_CHECK;
			S_CHECK: begin
				if (commit) begin
					state_n = S_IDLE;
				end else if (cont) begin
					state_n = S_READ;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready     = (state_q == S_IDLE);
		pctrl.start   = accept;
		pctrl.advance = cont;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (commit && do_write) begin
				valid_q[pstat.addr] <= 1'b1;
			end
			if (commit && do_clear) begin
				valid_q[pstat.addr] <= 1'b0;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.mode;
			key_q  <= req.key;
		end
		if (commit) begin
			rsp_status_q <= fin_status;
			rsp_slot_q   <= (fin_status == ST_OK) ? SLOT_W'(pstat.addr) : '0;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.slot_index = rsp_slot_q;
endmodule

// File: dv/tb_quadratic_probe_hash_table.sv
`timescale 1ns / 1ps
// Self-checking bench for quadratic_probe_hash_table: drives request words, mirrors the table.
// Depends on qpht_pkg, qpht_req_if, qpht_rsp_if and the block itself.
module tb_quadratic_probe_hash_table;
	import qpht_pkg::*;

	// The one mode code that the package leaves unnamed; the block must answer not found.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam int RESET_CYCLES  = 7;
	// Settling wait after the owed responses are back, with margin over the worst case.
	localparam int SETTLE_CYCLES = 4 * (2 + 2 * TABLE_SIZE);
	// A word must move on one side or the other at least this often.
	localparam int STUCK_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot_index;
	} rsp_word_t;

	logic clk;
	logic arst_n;

	qpht_req_if req ();
	qpht_rsp_if rsp ();

	quadratic_probe_hash_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// Mirror of the table: key store and occupancy bits.
	logic [KEY_W-1:0]  slot_key [TABLE_SIZE];
	bit [TABLE_SIZE-1:0] slot_used;

	// Responses the block still owes, oldest first.
	rsp_word_t pending_rsp [$];
	rsp_word_t want_rsp;

	int  fail_count;
	int  stuck_cycles;
	bit  src_idle_on;
	bit  rsp_idle_on;
	int  rsp_hold_len;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Apply one request to the mirror and return the response it must produce.
	function automatic rsp_word_t apply_request(input logic [MODE_W-1:0] op,
			input logic [KEY_W-1:0] k);
		rsp_word_t r;
		int home;
		int s;
		int i;
		bit done;
		r.status = ST_NOT_FOUND;
		r.slot_index = '0;
		done = 1'b0;
		home = int'(k % TABLE_SIZE);
		// Insert that runs out of probes reports full, even with a free slot left.
		if (op == MODE_INSERT)
			r.status = ST_FULL;
		for (i = 0; i < TABLE_SIZE && !done; i++) begin
			s = (home + (i * i) % TABLE_SIZE) % TABLE_SIZE;
			if (op == MODE_INSERT) begin
				if (!slot_used[s]) begin
					slot_used[s] = 1'b1;
					slot_key[s] = k;
					r.status = ST_OK;
					r.slot_index = SLOT_W'(s);
					done = 1'b1;
				end
			end else if (op == MODE_SEARCH || op == MODE_DELETE) begin
				// Stop at the first free slot on the probe path: no tombstones exist.
				if (!slot_used[s]) begin
					done = 1'b1;
				end else if (slot_key[s] == k) begin
					if (op == MODE_DELETE)
						slot_used[s] = 1'b0;
					r.status = ST_OK;
					r.slot_index = SLOT_W'(s);
					done = 1'b1;
				end
			end else begin
				// Unused code: leave the table alone.
				done = 1'b1;
			end
		end
		return r;
	endfunction

	// Draw a key: mostly from a few clustered groups so homes collide, sometimes anything.
	function automatic logic [KEY_W-1:0] fresh_key();
		logic [3:0] low;
		low = 4'($urandom);
		case ($urandom_range(0, 4))
			0: return KEY_W'($urandom);
			1: return {27'h0000000, low};
			2: return {27'h0000001, low};
			3: return {27'h5A5A5A5, low};
			default: return {27'h7FFFFFF, low};
		endcase
	endfunction

	// Draw a key that sits in the table right now, or a fresh one if the table is empty.
	function automatic logic [KEY_W-1:0] stored_key();
		logic [KEY_W-1:0] k;
		int start;
		int j;
		bit hit;
		k = fresh_key();
		hit = 1'b0;
		start = $urandom_range(0, TABLE_SIZE - 1);
		for (j = 0; j < TABLE_SIZE; j++) begin
			if (!hit && slot_used[(start + j) % TABLE_SIZE]) begin
				k = slot_key[(start + j) % TABLE_SIZE];
				hit = 1'b1;
			end
		end
		return k;
	endfunction

	// Offer one request word and hold it until accepted; record its response at acceptance.
	// Call at a rising edge at which valid has not been assigned yet.
	task automatic send_word(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] k);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.mode  <= op;
		req.key   <= k;
		do @(posedge clk); while (!req.ready);
		pending_rsp.push_back(apply_request(op, k));
	endtask

	// Drop valid and hold off until every owed response is back.
	task automatic wait_drained();
		req.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_fill_table();
		int k;
		// Keys 0..15 land in their home slots and leave every key entry written.
		for (k = 0; k < TABLE_SIZE; k++)
			send_word(MODE_INSERT, KEY_W'(k));
	endtask

	task automatic test_probe_limits();
		// Full table: insert runs out of probes, search of an absent key does too.
		send_word(MODE_INSERT, 31'h7FFFFFFF);
		send_word(MODE_SEARCH, 31'h7FFFFFFF);
		send_word(MODE_SEARCH, 31'd15);
		send_word(MODE_UNUSED, 31'h2AAAAAAA);
	endtask

	task automatic test_delete_hole();
		// Empty a slot, then hit it as the first probe on search and delete.
		send_word(MODE_DELETE, 31'd5);
		send_word(MODE_SEARCH, 31'd5);
		send_word(MODE_DELETE, 31'd5);
		// Refill the hole with a colliding key, then overflow that probe path.
		send_word(MODE_INSERT, 31'd21);
		send_word(MODE_SEARCH, 31'd21);
		send_word(MODE_INSERT, 31'h7FFFFFF5);
	endtask

	// One random request; the mix leans toward inserts when the table is sparse
	// and toward deletes when it is crowded, so occupancy keeps moving.
	task automatic send_random_word();
		int r;
		int occ;
		int ins_w;
		logic [MODE_W-1:0] op;
		logic [KEY_W-1:0] k;
		occ = $countones(slot_used);
		ins_w = (occ < 5) ? 60 : ((occ > 11) ? 20 : 40);
		r = $urandom_range(0, 99);
		if (r < 5)
			op = MODE_UNUSED;
		else if (r < 5 + ins_w)
			op = MODE_INSERT;
		else if ((r - ins_w) % 2 == 0)
			op = MODE_SEARCH;
		else
			op = MODE_DELETE;
		if (op != MODE_INSERT && $urandom_range(0, 9) < 7)
			k = stored_key();
		else
			k = fresh_key();
		send_word(op, k);
	endtask

	task automatic test_output_backpressure();
		// Stall the receiver for a long stretch and keep offering back to back.
		src_idle_on = 1'b0;
		rsp_hold_len = HOLD_CYCLES;
		repeat (12) send_random_word();
		src_idle_on = 1'b1;
	endtask

	task automatic test_random_traffic(input int count, input bit with_idle,
			input int drain_every);
		int n;
		src_idle_on = with_idle;
		rsp_idle_on = with_idle;
		for (n = 0; n < count; n++) begin
			if (drain_every > 0 && n > 0 && n % drain_every == 0)
				wait_drained();
			send_random_word();
		end
	endtask

	// Receiver: random stall bursts, plus one long hold on request.
	initial begin
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_hold_len > 0) begin
				rsp.ready <= 1'b0;
				repeat (rsp_hold_len) @(posedge clk);
				rsp_hold_len = 0;
				rsp.ready <= 1'b1;
			end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Checker: compare every accepted response word with the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected response word: status %0d slot_index %0d",
					rsp.status, rsp.slot_index);
				fail_count++;
			end else begin
				want_rsp = pending_rsp.pop_front();
				if (rsp.status !== want_rsp.status) begin
					$error("status: expected %0d, got %0d", want_rsp.status, rsp.status);
					fail_count++;
				end
				if (rsp.slot_index !== want_rsp.slot_index) begin
					$error("slot_index: expected %0d, got %0d",
						want_rsp.slot_index, rsp.slot_index);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run when no word moves on either side for too long.
	initial begin
		stuck_cycles = 0;
		while (stuck_cycles < STUCK_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		fail_count   = 0;
		slot_used    = '0;
		src_idle_on  = 1'b1;
		rsp_idle_on  = 1'b1;
		rsp_hold_len = 0;
		arst_n    <= 1'b0;
		req.valid <= 1'b0;
		req.mode  <= MODE_INSERT;
		req.key   <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_table();
		test_probe_limits();
		test_delete_hole();
		test_output_backpressure();
		test_random_traffic(750, 1'b1, 150);
		// Last stretch runs at full rate on both sides.
		test_random_traffic(150, 1'b0, 0);

		req.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
sv/qpht_pkg.sv
sv/qpht_req_if.sv
sv/qpht_rsp_if.sv
sv/qpht_ram.sv
sv/qpht_probe.sv
sv/quadratic_probe_hash_table.sv
dv/tb_quadratic_probe_hash_table.sv
